FILE: design/lqvr_pkg.sv
// lqvr_pkg: shared types and codes for the linear queue with value removal.
// No dependencies; used by every module of the block.
package lqvr_pkg;

  localparam int unsigned LqvrDepth = 8;
  localparam int unsigned DataW     = 32;
  localparam int unsigned FuncW     = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountW    = 4;
  localparam int unsigned OutDataW  = 40;

  localparam logic [FuncW-1:0] FUNC_PUSH   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_POP    = 2'd1;
  localparam logic [FuncW-1:0] FUNC_DELETE = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [StatusW-1:0] STATUS_NOTFOUND  = 2'd3;

  localparam logic [CountW-1:0] CountMax = 4'd15;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

FILE: design/linear_queue_with_value_removal_unit.sv
// Top level of the linear queue with value removal: a row of slot cells,
// head/tail pointers, the delete sequencer and the output register.
// Depends on lqvr_pkg and lqvr_cell.
//
// Push, pop and unused codes finish in the cycle the word is accepted and the
// result appears on the next cycle. A delete first registers its operand; then
// the cell row removes the lowest matching entry
// per cycle by shifting every cell above it down one place, and once no match
// is left and the output register is free it issues the result. No new word is taken while
// a delete runs. Slot contents have no reset; pointers reset to empty.
module linear_queue_with_value_removal_unit #(
  parameter int unsigned DEPTH = lqvr_pkg::LqvrDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [lqvr_pkg::DataW-1:0]      s_axis_tdata_i,  // operand_value
  input  logic [lqvr_pkg::FuncW-1:0]      s_axis_tuser_i,  // func
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [lqvr_pkg::OutDataW-1:0]   m_axis_tdata_o,  // read_value, removed_count, pad
  output logic [lqvr_pkg::StatusW-1:0]    m_axis_tuser_o   // status
);
  import lqvr_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned PW = $clog2(DEPTH + 2);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DEL  = 1'b1;

  logic             state_q, state_d;
  logic [PW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [DataW-1:0] operand_q;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic               m_valid_q;
  logic [DataW-1:0]   rd_q, rd_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [CountW-1:0]  cnt_out_q, cnt_out_d;
  logic               produce;

  logic [DataW-1:0] value [DEPTH];
  logic [DEPTH-1:0] match, hit, seen;
  cell_ctrl_t       ctrl [DEPTH];

  logic out_free, accept, full, any_hit, del_step, pop_clear, pop_ok;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = tail_q >= PW'(DEPTH);
  assign pop_clear       = head_q > tail_q;
  assign pop_ok          = !pop_clear && (head_q != '0) && (head_q <= PW'(DEPTH));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      hit[i] = match[i] && (head_q != '0) && (PW'(i + 1) >= head_q) &&
               (PW'(i + 1) <= tail_q);
    end
    seen[0] = hit[0];
    for (int i = 1; i < DEPTH; i++) begin
      seen[i] = seen[i-1] | hit[i];
    end
  end

  assign any_hit  = seen[DEPTH-1];
  assign del_step = (state_q == ST_DEL) && any_hit;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DataW-1:0] upper;
    if (g == DEPTH - 1) begin : g_top
      assign upper = value[g];
    end else begin : g_mid
      assign upper = value[g+1];
    end
    assign ctrl[g].load  = accept && (s_axis_tuser_i == FUNC_PUSH) && !full &&
                           (tail_q == PW'(g));
    assign ctrl[g].shift = del_step && seen[g];
    lqvr_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl[g]),
      .push_data_i (s_axis_tdata_i),
      .upper_i     (upper),
      .operand_i   (operand_q),
      .value_o     (value[g]),
      .match_o     (match[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    produce   = 1'b0;
    rd_d      = '1;
    status_d  = STATUS_OK;
    cnt_out_d = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser_i)
            FUNC_PUSH: begin
              produce = 1'b1;
              if (full) begin
                status_d = STATUS_OVERFLOW;
              end else begin
                tail_d = tail_q + PW'(1);
                if (head_q == '0) begin
                  head_d = PW'(1);
                end
              end
            end
            FUNC_POP: begin
              produce = 1'b1;
              if (pop_ok) begin
                rd_d   = value[IW'(head_q - PW'(1))];
                head_d = head_q + PW'(1);
              end else begin
                status_d = STATUS_UNDERFLOW;
                if (pop_clear) begin
                  head_d = '0;
                  tail_d = '0;
                end
              end
            end
            FUNC_DELETE: begin
              cnt_d   = '0;
              state_d = ST_DEL;
            end
            default: begin
              produce = 1'b1;
            end
          endcase
        end
      end
      ST_DEL: begin
        if (any_hit) begin
          tail_d = tail_q - PW'(1);
          cnt_d  = cnt_q + CW'(1);
        end else if (out_free) begin
          produce   = 1'b1;
          status_d  = (cnt_q == '0) ? STATUS_NOTFOUND : STATUS_OK;
          cnt_out_d = (int'(cnt_q) > int'(CountMax)) ? CountMax : CountW'(cnt_q);
          if ((cnt_q != '0) && (head_q > tail_q)) begin
            head_d = '0;
            tail_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      if (produce) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      operand_q <= s_axis_tdata_i;
    end
    if (produce) begin
      rd_q      <= rd_d;
      status_q  <= status_d;
      cnt_out_q <= cnt_out_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {(OutDataW - DataW - CountW)'(0), cnt_out_q, rd_q};
  assign m_axis_tuser_o  = status_q;

endmodule

FILE: design/lqvr_cell.sv
// lqvr_cell: one queue slot; loads a pushed word or takes its upper neighbour.
// Depends on lqvr_pkg.
module lqvr_cell (
  input  logic                         clk_i,
  input  lqvr_pkg::cell_ctrl_t         ctrl_i,
  input  logic [lqvr_pkg::DataW-1:0]   push_data_i,
  input  logic [lqvr_pkg::DataW-1:0]   upper_i,
  input  logic [lqvr_pkg::DataW-1:0]   operand_i,
  output logic [lqvr_pkg::DataW-1:0]   value_o,
  output logic                         match_o
);
  import lqvr_pkg::*;

  logic [DataW-1:0] value_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      value_q <= push_data_i;
    end else if (ctrl_i.shift) begin
      value_q <= upper_i;
    end
  end

  assign value_o = value_q;
  assign match_o = (value_q == operand_i);

endmodule

FILE: design/lqvr_checker.sv
// lqvr_checker: port-level assertions for the queue, bound to the top level.
// Depends on lqvr_pkg and linear_queue_with_value_removal_unit.
module lqvr_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  input  logic                            s_axis_tready_o,
  input  logic [lqvr_pkg::DataW-1:0]      s_axis_tdata_i,
  input  logic [lqvr_pkg::FuncW-1:0]      s_axis_tuser_i,
  input  logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  input  logic [lqvr_pkg::OutDataW-1:0]   m_axis_tdata_o,
  input  logic [lqvr_pkg::StatusW-1:0]    m_axis_tuser_o
);
  import lqvr_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // failed operations return -1 and no count
  a_fail_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STATUS_OVERFLOW ||
      m_axis_tuser_o == STATUS_UNDERFLOW || m_axis_tuser_o == STATUS_NOTFOUND) |->
      (m_axis_tdata_o[DataW-1:0] == '1) && (m_axis_tdata_o[DataW+CountW-1:DataW] == '0))
    else $error("failed operation with bad payload");

  // a removal count only comes with ok status and no read value
  a_count_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[DataW+CountW-1:DataW] != '0) |->
      (m_axis_tuser_o == STATUS_OK) && (m_axis_tdata_o[DataW-1:0] == '1))
    else $error("removal count on non-delete result");

  // a delete holds off new input words once it has been accepted
  a_del_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i == FUNC_DELETE) |=>
      !s_axis_tready_o)
    else $error("input taken during delete");

endmodule

bind linear_queue_with_value_removal_unit lqvr_checker u_lqvr_checker (.*);

FILE: tb/sv/lqvr_scoreboard.sv
// lqvr_scoreboard: watches both stream channels of the linear queue, keeps its own
// copy of the slot array and pointers, and checks every result word in order.
// Depends on lqvr_pkg.
`timescale 1ns / 1ps

module lqvr_scoreboard (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [lqvr_pkg::DataW-1:0]      in_data_i,   // operand_value
  input  logic [lqvr_pkg::FuncW-1:0]      in_user_i,   // func
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic [lqvr_pkg::OutDataW-1:0]   out_data_i,  // read_value, removed_count, pad
  input  logic [lqvr_pkg::StatusW-1:0]    out_user_i,  // status
  output int unsigned                     fail_count_o,
  output int unsigned                     pending_o,
  output int unsigned                     checked_o
);
  import lqvr_pkg::*;

  typedef struct packed {
    logic [DataW-1:0]   read_value;
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  removed_count;
  } queue_result_t;

  logic [DataW-1:0] slots [LqvrDepth];
  int unsigned      head_p1;
  int unsigned      tail_p1;
  queue_result_t    awaited_q[$];
  queue_result_t    want;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
  end

  function automatic queue_result_t apply_word(logic [FuncW-1:0] fn, logic [DataW-1:0] val);
    queue_result_t res;
    int unsigned   keep;
    int unsigned   hits;
    int unsigned   idx;
    res.read_value    = '1;
    res.status        = STATUS_OK;
    res.removed_count = '0;
    hits = 0;
    case (fn)
      FUNC_PUSH: begin
        if (tail_p1 >= LqvrDepth) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          slots[tail_p1] = val;
          tail_p1++;
          if (head_p1 == 0) head_p1 = 1;
        end
      end
      FUNC_POP: begin
        if (head_p1 > tail_p1) begin
          head_p1 = 0;
          tail_p1 = 0;
        end
        if (head_p1 != 0 && head_p1 <= LqvrDepth) begin
          res.read_value = slots[head_p1-1];
          head_p1++;
        end else begin
          res.status = STATUS_UNDERFLOW;
        end
      end
      FUNC_DELETE: begin
        if (head_p1 != 0 && head_p1 <= tail_p1 && tail_p1 <= LqvrDepth) begin
          keep = head_p1 - 1;
          for (idx = head_p1 - 1; idx < tail_p1; idx++) begin
            if (slots[idx] == val) begin
              hits++;
            end else begin
              slots[keep] = slots[idx];
              keep++;
            end
          end
          tail_p1 -= hits;
          if (head_p1 > tail_p1) begin
            head_p1 = 0;
            tail_p1 = 0;
          end
        end
        if (hits == 0) res.status = STATUS_NOTFOUND;
      end
      default: ;
    endcase
    res.removed_count = (hits > CountMax) ? CountMax : hits[CountW-1:0];
    return res;
  endfunction

  task automatic flag(string field, logic [DataW-1:0] exp_v, logic [DataW-1:0] act_v);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_p1 = 0;
      tail_p1 = 0;
      awaited_q.delete();
      pending_o = 0;
    end else begin
      // results first: a word accepted at this edge cannot answer at the same edge
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (awaited_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("[%0t] result word %h/%h with nothing outstanding",
                     $realtime, out_data_i, out_user_i);
        end else begin
          want = awaited_q.pop_front();
          if (out_data_i[DataW-1:0] !== want.read_value)
            flag("read_value", want.read_value, out_data_i[DataW-1:0]);
          if (out_data_i[DataW+CountW-1:DataW] !== want.removed_count)
            flag("removed_count", 32'(want.removed_count), 32'(out_data_i[DataW+CountW-1:DataW]));
          if (out_user_i !== want.status)
            flag("status", 32'(want.status), 32'(out_user_i));
          if (out_data_i[OutDataW-1:DataW+CountW] !== '0)
            flag("pad", '0, 32'(out_data_i[OutDataW-1:DataW+CountW]));
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_q.insert(awaited_q.size(), apply_word(in_user_i, in_data_i));
      pending_o = awaited_q.size();
    end
  end

endmodule

FILE: tb/sv/linear_queue_with_value_removal_unit_tb.sv
// linear_queue_with_value_removal_unit_tb: drives push, pop, delete and unused-code words into
// the queue with random idling and back-pressure; lqvr_scoreboard does the checking.
// Depends on lqvr_pkg, lqvr_scoreboard and linear_queue_with_value_removal_unit.
`timescale 1ns / 1ps

module linear_queue_with_value_removal_unit_tb;
  import lqvr_pkg::*;

  localparam int unsigned RandomWords = 700;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned LongHold    = 80;
  localparam logic [FuncW-1:0] FUNC_UNUSED = 2'd3;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [DataW-1:0]    s_data  = '0;
  logic [FuncW-1:0]    s_user  = FUNC_PUSH;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic [StatusW-1:0]  m_user;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned words_taken = 0;
  int unsigned sent_by_fn [4] = '{0, 0, 0, 0};
  bit          sender_calm = 1'b0;

  logic [DataW-1:0] value_pool [4] = '{32'd3, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0011};

  always #5 clk = ~clk;

  linear_queue_with_value_removal_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  lqvr_scoreboard u_scoreboard (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (s_valid),
    .in_ready_i   (s_ready),
    .in_data_i    (s_data),
    .in_user_i    (s_user),
    .out_valid_i  (m_valid),
    .out_ready_i  (m_ready),
    .out_data_i   (m_data),
    .out_user_i   (m_user),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_word(logic [FuncW-1:0] fn, logic [DataW-1:0] val);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= val;
    s_user  <= fn;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    sent_by_fn[fn]++;
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return value_pool[$urandom_range(0, 3)];
  endfunction

  // receiver: short random stalls, two long hold-offs to back the queue up
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = ((words_taken / 64) % 4 == 3) ? 0 : $urandom_range(0, 5);
      if (words_taken == 150 || words_taken == 500) stall = LongHold;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      @(posedge clk);
      while (!m_valid) @(posedge clk);
      words_taken++;
    end
  end

  initial begin
    int unsigned roll;
    int unsigned push_cut;
    int unsigned pop_cut;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, unused code, sign extremes, overflow, adjacent duplicates,
    // drained queue, push with head past tail, delete that empties the queue
    send_word(FUNC_POP,    32'h0);
    send_word(FUNC_DELETE, 32'h0);
    send_word(FUNC_UNUSED, 32'hFFFF_FFFF);
    send_word(FUNC_PUSH,   32'h8000_0000);
    send_word(FUNC_PUSH,   32'h7FFF_FFFF);
    send_word(FUNC_PUSH,   32'h0);
    send_word(FUNC_PUSH,   32'hFFFF_FFFF);
    repeat (4) send_word(FUNC_PUSH, 32'd5);
    send_word(FUNC_PUSH,   32'd1);
    send_word(FUNC_DELETE, 32'd5);
    send_word(FUNC_POP,    32'h0);
    send_word(FUNC_POP,    32'h0);
    send_word(FUNC_DELETE, 32'h0);
    send_word(FUNC_DELETE, 32'd42);
    send_word(FUNC_POP,    32'h0);
    send_word(FUNC_DELETE, 32'hFFFF_FFFF);
    send_word(FUNC_PUSH,   32'd7);
    send_word(FUNC_POP,    32'h0);
    send_word(FUNC_POP,    32'h0);
    send_word(FUNC_PUSH,   32'd9);
    send_word(FUNC_DELETE, 32'd9);
    send_word(FUNC_POP,    32'h0);
    drain_results();

    // alternate fill-heavy and drain-heavy stretches so both ends get exercised
    for (int unsigned i = 0; i < RandomWords; i++) begin
      sender_calm = ((i / 50) % 5 == 4);
      if ((i / 40) % 2 == 0) begin
        push_cut = 60;
        pop_cut  = 80;
      end else begin
        push_cut = 25;
        pop_cut  = 75;
      end
      if (i == RandomWords / 2) drain_results();
      roll = $urandom_range(0, 99);
      if (roll < push_cut)     send_word(FUNC_PUSH, pick_value());
      else if (roll < pop_cut) send_word(FUNC_POP, $urandom());
      else if (roll < 96)      send_word(FUNC_DELETE, pick_value());
      else                     send_word(FUNC_UNUSED, $urandom());
    end
    drain_results();
    repeat (20) @(posedge clk);

    $display("Sent %0d push, %0d pop, %0d delete and %0d unused-code words; %0d results checked",
             sent_by_fn[FUNC_PUSH], sent_by_fn[FUNC_POP], sent_by_fn[FUNC_DELETE],
             sent_by_fn[FUNC_UNUSED], checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
